// File: rtl/core/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, codes and helpers for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int TAG_WIDTH_DEFAULT = 16;
   localparam int KEY_MAX_WIDTH     = 48;

   localparam int KIND_BITS   = 2;
   localparam int KEY_BITS    = 32;
   localparam int TAG_BITS    = 16;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 5;
   localparam int REQ_BITS    = 56;
   localparam int RSP_BITS    = 56;

   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_PEEK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RISE,
      ST_RISE_CMP,
      ST_POP_LD,
      ST_SINK,
      ST_SINK_L,
      ST_SINK_R,
      ST_SINK_C,
      ST_SCAN_CMP,
      ST_RM_LD,
      ST_RM_CMP,
      ST_DONE
   } state_type;

   // true when key a is served ahead of key b (strict)
   function automatic logic comes_first(input logic [KEY_MAX_WIDTH-1:0] a,
                                        input logic [KEY_MAX_WIDTH-1:0] b,
                                        input logic                     mode);
      comes_first = mode ? (a > b) : (a < b);
   endfunction

endpackage

// File: rtl/core/bhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_ram
// Heap entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
   parameter int ADDR_WIDTH = 4,
   parameter int DATA_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [2**ADDR_WIDTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top
// Array-backed binary heap with push, pop, remove-by-tag and peek requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. The heap sits in a single-port-read,
// single-port-write RAM with registered read data, and every sift step is a
// read followed by a compare and a write, so the cost follows the heap depth.
// Peek, refused requests and a push into an empty heap go straight to the
// done state; push rises level by level, pop sinks level by level, and
// remove scans entries up to the match and then repairs as pop or push does.
// The result sits in an output register, so a new request can be taken
// while the previous result waits for rsp_tready.
module binary_heap_priority_queue_top #(
   parameter int DEPTH     = bhpq_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEFAULT,
   parameter int TAG_WIDTH = bhpq_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // kind[1:0], item_key[33:2], item_tag[49:34], zero pad
   input  logic [bhpq_pkg::REQ_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status[1:0], top_key[33:2], top_tag[49:34], entry_count[54:50], is_empty[55]
   output logic [bhpq_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data
);

   import bhpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = AW + 2;
   localparam int DW = KEY_WIDTH + TAG_WIDTH;

   state_type state_ff, state_in;

   logic                 mode_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        pick_idx_ff, pick_idx_in;
   logic [KEY_WIDTH-1:0] cur_key_ff, cur_key_in;
   logic [TAG_WIDTH-1:0] cur_tag_ff, cur_tag_in;
   logic [KEY_WIDTH-1:0] pick_key_ff, pick_key_in;
   logic [TAG_WIDTH-1:0] pick_tag_ff, pick_tag_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   status_type           status_ff, status_in;
   logic [KEY_WIDTH-1:0] top_key_ff;
   logic [TAG_WIDTH-1:0] top_tag_ff;
   logic                 rsp_valid_ff;
   logic [RSP_BITS-1:0]  rsp_data_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [DW-1:0] mem_rdata;

   kind_type             req_kind;
   logic [KEY_WIDTH-1:0] req_key;
   logic [TAG_WIDTH-1:0] req_tag;
   logic                 req_fire;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [TAG_WIDTH-1:0] rd_tag;

   logic          is_full, is_none, pos_zero;
   logic [AW-1:0] pos_up, cnt_up;
   logic [LW-1:0] left_w, right_w, cnt_w;
   logic          left_out, right_in;
   logic          up_wins, right_wins, pick_wins, tag_hit, scan_last, hit_tail;
   logic          out_free;

   bhpq_ram #(
      .ADDR_WIDTH (AW),
      .DATA_WIDTH (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_kind = kind_type'(req_tdata[1:0]);
   assign req_key  = KEY_WIDTH'(req_tdata[33:2]);
   assign req_tag  = TAG_WIDTH'(req_tdata[49:34]);
   assign rd_key   = mem_rdata[DW-1:TAG_WIDTH];
   assign rd_tag   = mem_rdata[TAG_WIDTH-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign is_full  = (cnt_ff == CW'(DEPTH));
   assign is_none  = (cnt_ff == '0);
   assign pos_zero = (pos_ff == '0);
   assign pos_up   = AW'((pos_ff - AW'(1)) >> 1);
   // parent of the slot a push lands in (cnt_ff < DEPTH there)
   assign cnt_up   = AW'((cnt_ff - CW'(1)) >> 1);
   assign cnt_w    = LW'(cnt_ff);
   assign left_w   = (LW'(pos_ff) << 1) + LW'(1);
   assign right_w  = LW'(idx_ff) + LW'(1);
   assign left_out = (left_w >= cnt_w);
   assign right_in = (right_w < cnt_w);

   assign up_wins    = comes_first(KEY_MAX_WIDTH'(cur_key_ff), KEY_MAX_WIDTH'(rd_key), mode_ff);
   assign right_wins = comes_first(KEY_MAX_WIDTH'(rd_key), KEY_MAX_WIDTH'(pick_key_ff), mode_ff);
   assign pick_wins  = comes_first(KEY_MAX_WIDTH'(pick_key_ff), KEY_MAX_WIDTH'(cur_key_ff),
                                   mode_ff);
   assign tag_hit    = (rd_tag == tag_ff);
   assign scan_last  = ((CW'(idx_ff) + CW'(1)) >= cnt_ff);
   assign hit_tail   = ((CW'(idx_ff) + CW'(1)) == cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  KIND_PUSH:   state_in = (is_full || is_none) ? ST_DONE : ST_RISE_CMP;
                  KIND_POP:    state_in = is_none ? ST_DONE : ST_POP_LD;
                  KIND_REMOVE: state_in = is_none ? ST_DONE : ST_SCAN_CMP;
                  KIND_PEEK:   state_in = ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_RISE:     state_in = pos_zero ? ST_DONE : ST_RISE_CMP;
         ST_RISE_CMP: state_in = up_wins ? ST_RISE : ST_DONE;
         ST_POP_LD:   state_in = ST_SINK;
         ST_SINK:     state_in = left_out ? ST_DONE : ST_SINK_L;
         ST_SINK_L:   state_in = right_in ? ST_SINK_R : ST_SINK_C;
         ST_SINK_R:   state_in = ST_SINK_C;
         ST_SINK_C:   state_in = pick_wins ? ST_SINK : ST_DONE;
         ST_SCAN_CMP: begin
            if (tag_hit) begin
               state_in = hit_tail ? ST_DONE : ST_RM_LD;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_RM_LD:    state_in = pos_zero ? ST_SINK : ST_RM_CMP;
         ST_RM_CMP:   state_in = up_wins ? ST_RISE : ST_SINK;
         ST_DONE:     state_in = out_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      pick_idx_in = pick_idx_ff;
      cur_key_in  = cur_key_ff;
      cur_tag_in  = cur_tag_ff;
      pick_key_in = pick_key_ff;
      pick_tag_in = pick_tag_ff;
      tag_in      = tag_ff;
      status_in   = status_ff;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff;
      mem_wdata   = {cur_key_ff, cur_tag_ff};
      mem_raddr   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in  = STATUS_OK;
               cur_key_in = req_key;
               cur_tag_in = req_tag;
               tag_in     = req_tag;
               unique case (req_kind)
                  KIND_PUSH: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cnt_in    = cnt_ff + CW'(1);
                        pos_in    = AW'(cnt_ff);
                        mem_raddr = cnt_up;
                        if (is_none) begin
                           mem_we    = 1'b1;
                           mem_waddr = '0;
                           mem_wdata = {req_key, req_tag};
                        end
                     end
                  end
                  KIND_POP: begin
                     if (is_none) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cnt_in    = cnt_ff - CW'(1);
                        mem_raddr = AW'(cnt_ff - CW'(1));
                     end
                  end
                  KIND_REMOVE: begin
                     status_in = STATUS_NOT_FOUND;
                     idx_in    = '0;
                     mem_raddr = '0;
                  end
                  KIND_PEEK: begin
                     status_in = STATUS_OK;
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_RISE: begin
            if (pos_zero) begin
               mem_we = 1'b1;
            end else begin
               mem_raddr = pos_up;
            end
         end
         ST_RISE_CMP, ST_RM_CMP: begin
            if (up_wins) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               pos_in    = pos_up;
            end else if (state_ff == ST_RISE_CMP) begin
               mem_we = 1'b1;
            end
         end
         ST_POP_LD: begin
            cur_key_in = rd_key;
            cur_tag_in = rd_tag;
            pos_in     = '0;
         end
         ST_SINK: begin
            if (left_out) begin
               mem_we = 1'b1;
            end else begin
               mem_raddr = AW'(left_w);
               idx_in    = AW'(left_w);
            end
         end
         ST_SINK_L: begin
            pick_key_in = rd_key;
            pick_tag_in = rd_tag;
            pick_idx_in = idx_ff;
            mem_raddr   = AW'(right_w);
         end
         ST_SINK_R: begin
            if (right_wins) begin
               pick_key_in = rd_key;
               pick_tag_in = rd_tag;
               pick_idx_in = AW'(right_w);
            end
         end
         ST_SINK_C: begin
            mem_we = 1'b1;
            if (pick_wins) begin
               mem_wdata = {pick_key_ff, pick_tag_ff};
               pos_in    = pick_idx_ff;
            end
         end
         ST_SCAN_CMP: begin
            if (tag_hit) begin
               status_in = STATUS_OK;
               cnt_in    = cnt_ff - CW'(1);
               pos_in    = idx_ff;
               mem_raddr = AW'(cnt_ff - CW'(1));
            end else if (!scan_last) begin
               idx_in    = idx_ff + AW'(1);
               mem_raddr = idx_ff + AW'(1);
            end
         end
         ST_RM_LD: begin
            cur_key_in = rd_key;
            cur_tag_in = rd_tag;
            mem_raddr  = pos_up;
         end
         ST_DONE: begin
            status_in = status_ff;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      pick_idx_ff <= pick_idx_in;
      cur_key_ff  <= cur_key_in;
      cur_tag_ff  <= cur_tag_in;
      pick_key_ff <= pick_key_in;
      pick_tag_ff <= pick_tag_in;
      tag_ff      <= tag_in;
      status_ff   <= status_in;
      // shadow of slot 0 for the result
      if (mem_we && mem_waddr == '0) begin
         top_key_ff <= mem_wdata[DW-1:TAG_WIDTH];
         top_tag_ff <= mem_wdata[TAG_WIDTH-1:0];
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {is_none,
                         COUNT_BITS'(cnt_ff),
                         is_none ? TAG_BITS'(0) : TAG_BITS'(top_tag_ff),
                         is_none ? KEY_BITS'(0) : KEY_BITS'(top_key_ff),
                         status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sim/tb_binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_top
// Self-checking bench for the binary heap priority queue. Requests go in on
// the request stream and a software heap predicts every response. Responses
// are checked field by field in order. Both stream sides idle at random, and
// the min/max order is switched between phases while the queue is quiet.
// ----------------------------------------------------------------------------

class heap_scoreboard;
   localparam int HDEPTH = 16;
   bit [31:0]       key_q[HDEPTH];
   bit [15:0]       tag_q[HDEPTH];
   int unsigned     held;
   bit              max_first;
   logic [55:0]     pending[$];
   int              errors;

   function new();
      held = 0;
      max_first = 0;
      errors = 0;
   endfunction

   function bit ahead(int a, int b);
      return max_first ? (key_q[a] > key_q[b]) : (key_q[a] < key_q[b]);
   endfunction

   function void swap_slots(int a, int b);
      bit [31:0] k;
      bit [15:0] t;
      k = key_q[a]; key_q[a] = key_q[b]; key_q[b] = k;
      t = tag_q[a]; tag_q[a] = tag_q[b]; tag_q[b] = t;
   endfunction

   function void sift_up(int p);
      int up;
      while (p > 0) begin
         up = (p - 1) / 2;
         if (!ahead(p, up)) break;
         swap_slots(p, up);
         p = up;
      end
   endfunction

   function void sift_down(int p);
      int l;
      int pick;
      forever begin
         l = 2 * p + 1;
         if (l >= held) break;
         pick = l;
         if (l + 1 < held && ahead(l + 1, l)) pick = l + 1;
         if (!ahead(pick, p)) break;
         swap_slots(pick, p);
         p = pick;
      end
   endfunction

   // note an accepted request transaction and queue the response it causes
   function void note_request(bhpq_pkg::kind_type kind, bit [31:0] key, bit [15:0] tag);
      bhpq_pkg::status_type st;
      int i;
      st = bhpq_pkg::STATUS_OK;
      case (kind)
         bhpq_pkg::KIND_PUSH: begin
            if (held >= HDEPTH) st = bhpq_pkg::STATUS_FULL;
            else begin
               key_q[held] = key;
               tag_q[held] = tag;
               held++;
               sift_up(held - 1);
            end
         end
         bhpq_pkg::KIND_POP: begin
            if (held == 0) st = bhpq_pkg::STATUS_EMPTY;
            else begin
               held--;
               key_q[0] = key_q[held];
               tag_q[0] = tag_q[held];
               sift_down(0);
            end
         end
         bhpq_pkg::KIND_REMOVE: begin
            st = bhpq_pkg::STATUS_NOT_FOUND;
            for (i = 0; i < held; i++) begin
               if (tag_q[i] == tag) begin
                  held--;
                  if (i < held) begin
                     key_q[i] = key_q[held];
                     tag_q[i] = tag_q[held];
                     if (i > 0 && ahead(i, (i - 1) / 2)) sift_up(i);
                     else sift_down(i);
                  end
                  st = bhpq_pkg::STATUS_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      pending.push_back({held == 0, 5'(held), held ? tag_q[0] : 16'd0,
                         held ? key_q[0] : 32'd0, st});
   endfunction

   function void check_response(logic [55:0] got);
      logic [55:0] exp;
      if (pending.size() == 0) begin
         $error("response with nothing expected: %h", got);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got[1:0] !== exp[1:0]) begin
         $error("status expected %0d actual %0d", exp[1:0], got[1:0]); errors++;
      end
      if (got[33:2] !== exp[33:2]) begin
         $error("top_key expected %h actual %h", exp[33:2], got[33:2]); errors++;
      end
      if (got[49:34] !== exp[49:34]) begin
         $error("top_tag expected %h actual %h", exp[49:34], got[49:34]); errors++;
      end
      if (got[54:50] !== exp[54:50]) begin
         $error("entry_count expected %0d actual %0d", exp[54:50], got[54:50]);
         errors++;
      end
      if (got[55] !== exp[55]) begin
         $error("is_empty expected %0d actual %0d", exp[55], got[55]); errors++;
      end
   endfunction
endclass

module tb_binary_heap_priority_queue_top;
   import bhpq_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   heap_scoreboard queue_model;
   int          idle_cycles;
   bit [15:0]   live_tags[$];

   binary_heap_priority_queue_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial queue_model = new();

   // response side: random stall per transaction, checked at the rising edge
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         repeat (gap) @(negedge clock);
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
         queue_model.check_response(rsp_tdata);
         @(negedge clock);
         rsp_tready = 0;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_binary_heap_priority_queue_top: FAIL");
         $finish;
      end
   end

   task automatic send_request(kind_type kind, bit [31:0] key, bit [15:0] tag,
                               bit allow_gap);
      int gap;
      gap = allow_gap ? $urandom_range(0, 7) : 0;
      repeat (gap) @(negedge clock);
      req_tdata  = {6'd0, tag, key, kind};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      queue_model.note_request(kind, key, tag);
      if (kind == KIND_PUSH) live_tags.push_back(tag);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic drain_queue();
      while (queue_model.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_order(bit mode);
      csr_data  = mode;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      queue_model.max_first = mode;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic bit [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [15:0] pick_tag();
      if (live_tags.size() != 0 && $urandom_range(0, 2) != 0)
         return live_tags[$urandom_range(0, live_tags.size() - 1)];
      return ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 15));
   endfunction

   task automatic random_phase(int count);
      kind_type kind;
      int w;
      for (int n = 0; n < count; n++) begin
         w = $urandom_range(0, 9);
         // lean toward pushes when shallow, pops when near full
         if (queue_model.held < 4)
            kind = (w < 6) ? KIND_PUSH : kind_type'($urandom_range(1, 3));
         else if (queue_model.held > 13)
            kind = (w < 5) ? KIND_POP : kind_type'($urandom_range(0, 3));
         else kind = kind_type'($urandom_range(0, 3));
         send_request(kind, pick_key(), pick_tag(), ($urandom_range(0, 4) != 0));
         if (n == count / 2) drain_queue();
      end
   endtask

   initial begin
      bit mode;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_data = 0;
      idle_cycles = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty-heap cases, fill to full, ties, remove paths
      send_request(KIND_PEEK, 32'hFFFF_FFFF, 16'hFFFF, 0);
      send_request(KIND_POP, 0, 0, 0);
      send_request(KIND_REMOVE, 0, 16'h1234, 0);
      for (int i = 0; i < 16; i++)
         send_request(KIND_PUSH, (i == 0) ? 32'hFFFF_FFFF : (i % 3 == 0 ? 32'd5 : 32'(i * 7)),
                      (i == 15) ? 16'hFFFF : 16'(i), 1);
      send_request(KIND_PUSH, 32'd0, 16'hABCD, 0);
      send_request(KIND_REMOVE, 0, 16'd9, 0);
      send_request(KIND_REMOVE, 0, 16'hBEEF, 0);
      send_request(KIND_POP, 0, 0, 1);
      send_request(KIND_PEEK, 0, 0, 1);
      drain_queue();

      write_order(1);
      send_request(KIND_PUSH, 32'hAAAA_5555, 16'h5555, 0);
      send_request(KIND_REMOVE, 0, 16'hFFFF, 0);
      drain_queue();

      for (int p = 0; p < 6; p++) begin
         live_tags.delete();
         while (queue_model.held != 0) send_request(KIND_POP, 0, 0, 1);
         drain_queue();
         mode = (p == 0) ? 0 : $urandom_range(0, 1);
         write_order(mode);
         random_phase(270);
         drain_queue();
      end

      drain_queue();
      if (queue_model.errors == 0)
         $display("tb_binary_heap_priority_queue_top: PASS");
      else
         $display("tb_binary_heap_priority_queue_top: FAIL");
      $finish;
   end

endmodule
